// ===== hdl/bmi_pkg.sv =====
`default_nettype none
package bmi_pkg;

   localparam int WORD_BITS = 32;

   typedef logic [WORD_BITS-1:0] word_type;

   localparam word_type WORD_ONE      = word_type'(1);
   localparam word_type MODULUS_RESET = word_type'(3);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic fin_err;
      logic fin_x1;
      logic fin_x2;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic p_bad;
      logic u_zero;
      logic v_zero;
      logic u_one;
      logic v_one;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/binary_modular_inverse_top.sv =====
// a computation is a load, then a data-dependent run of steps, then a finish; result strobe in the next cycle
// each step is one halve or subtract of u/v per cycle
// throughput: one item at a time, next start taken in the cycle the result is shown
// the receiver cannot stall: rsp_valid is a one cycle strobe
// reset (synchronous, active high) returns to idle and sets the modulus to 3
`default_nettype none
module binary_modular_inverse_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  bmi_pkg::word_type  req_operand,
   output logic               rsp_valid,
   output bmi_pkg::word_type  rsp_inverse,
   output logic               rsp_not_invertible,
   input  wire                csr_write,
   input  bmi_pkg::word_type  csr_wdata
);
   import bmi_pkg::*;

   cmd_type    cmd;
   status_type status;

   bmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   bmi_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_wdata          (csr_wdata),
      .req_operand        (req_operand),
      .cmd                (cmd),
      .status             (status),
      .rsp_inverse        (rsp_inverse),
      .rsp_not_invertible (rsp_not_invertible)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not start a computation");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_not_invertible) |-> (rsp_inverse == '0))
      else $error("error result with nonzero inverse");
`endif

endmodule
`default_nettype wire

// ===== hdl/bmi_ctrl.sv =====
`default_nettype none
module bmi_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   output logic                rsp_valid,
   output bmi_pkg::cmd_type    cmd,
   input  bmi_pkg::status_type status
);
   import bmi_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // zero in u or v means a common factor (or a zero operand)
            priority if (status.p_bad || status.u_zero || status.v_zero) begin
               cmd.fin_err = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.u_one) begin
               cmd.fin_x1 = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.v_one) begin
               cmd.fin_x2 = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      valid_in = cmd.fin_err | cmd.fin_x1 | cmd.fin_x2;
   end

   assign busy      = (state_ff == ST_RUN);
   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// ===== hdl/bmi_datapath.sv =====
`default_nettype none
module bmi_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_write,
   input  bmi_pkg::word_type    csr_wdata,
   input  bmi_pkg::word_type    req_operand,
   input  bmi_pkg::cmd_type     cmd,
   output bmi_pkg::status_type  status,
   output bmi_pkg::word_type    rsp_inverse,
   output logic                 rsp_not_invertible
);
   import bmi_pkg::*;

   word_type modulus_ff;
   word_type u_ff, u_in, v_ff, v_in;
   word_type x1_ff, x1_in, x2_ff, x2_in;
   word_type inv_ff, inv_in;
   logic     err_ff, err_in;

   word_type half_src, half_res;
   word_type sub_big, sub_small, sub_res;
   word_type xa, xb, xdiff, xsub_res;
   logic     u_ge_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (csr_write) begin
         modulus_ff <= csr_wdata;
      end
   end

   // halve one coefficient mod p: add p when odd, folded into the shift
   always_comb begin
      half_src = (!u_ff[0]) ? x1_ff : x2_ff;
      if (half_src[0]) begin
         half_res = (half_src >> 1) + (modulus_ff >> 1) + WORD_ONE;
      end else begin
         half_res = half_src >> 1;
      end
   end

   // subtract smaller from larger, coefficients reduced into [0, p)
   always_comb begin
      u_ge_v    = (u_ff >= v_ff);
      sub_big   = u_ge_v ? u_ff : v_ff;
      sub_small = u_ge_v ? v_ff : u_ff;
      sub_res   = sub_big - sub_small;
      xa        = u_ge_v ? x1_ff : x2_ff;
      xb        = u_ge_v ? x2_ff : x1_ff;
      xdiff     = xa - xb;
      xsub_res  = (xa >= xb) ? xdiff : xdiff + modulus_ff;
   end

   always_comb begin
      u_in  = u_ff;
      v_in  = v_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      priority if (cmd.load) begin
         // the operand is not reduced first: the gcd and the inverse are the same
         u_in  = req_operand;
         v_in  = modulus_ff;
         x1_in = WORD_ONE;
         x2_in = '0;
      end else if (cmd.step) begin
         priority if (!u_ff[0]) begin
            u_in  = u_ff >> 1;
            x1_in = half_res;
         end else if (!v_ff[0]) begin
            v_in  = v_ff >> 1;
            x2_in = half_res;
         end else if (u_ge_v) begin
            u_in  = sub_res;
            x1_in = xsub_res;
         end else begin
            v_in  = sub_res;
            x2_in = xsub_res;
         end
      end else begin
         u_in = u_ff;
      end
   end

   always_comb begin
      inv_in = inv_ff;
      err_in = err_ff;
      priority if (cmd.fin_err) begin
         inv_in = '0;
         err_in = 1'b1;
      end else if (cmd.fin_x1) begin
         inv_in = x1_ff;
         err_in = 1'b0;
      end else if (cmd.fin_x2) begin
         inv_in = x2_ff;
         err_in = 1'b0;
      end else begin
         inv_in = inv_ff;
      end
   end

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      v_ff   <= v_in;
      x1_ff  <= x1_in;
      x2_ff  <= x2_in;
      inv_ff <= inv_in;
      err_ff <= err_in;
   end

   assign status.p_bad  = (!modulus_ff[0]) || (modulus_ff < MODULUS_RESET);
   assign status.u_zero = (u_ff == '0);
   assign status.v_zero = (v_ff == '0);
   assign status.u_one  = (u_ff == WORD_ONE);
   assign status.v_one  = (v_ff == WORD_ONE);

   assign rsp_inverse        = inv_ff;
   assign rsp_not_invertible = err_ff;

endmodule
`default_nettype wire
